FILE: design/nearest_neighbor_frame_scaler_assert.svh
// Assertion macros for the nearest-neighbor frame scaler.
// Used by the top level; it depends on nothing else.
`ifndef NEAREST_NEIGHBOR_FRAME_SCALER_ASSERT_SVH
`define NEAREST_NEIGHBOR_FRAME_SCALER_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define NNFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define NNFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/nnfs_pkg.sv
// Shared constants for the nearest-neighbor frame scaler.
// Used by the interfaces, nnfs_palette and the top level; depends on nothing.
package nnfs_pkg;

  localparam int PIX_W       = 8;
  localparam int WORD_W      = 32;
  localparam int COORD_W     = 8;
  localparam int FRAC_W      = 16;
  localparam int PAL_DEPTH   = 256;
  localparam int PAL_AW      = 8;
  localparam int MAX_RESULTS = 64;
  localparam int RES_W       = 7;
  localparam int REG_W       = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int MIN_COLS    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_COLS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_MODE  = 2'd2;

  localparam logic [REG_W-1:0] RST_SRC_COLS = 13'd256;
  localparam logic [REG_W-1:0] RST_SRC_ROWS = 13'd256;

  localparam logic FUNC_PIXEL     = 1'b0;
  localparam logic FUNC_PAL_WRITE = 1'b1;

endpackage

FILE: design/nnfs_in_if.sv
// Input channel of the frame scaler: source pixels and palette writes.
// Depends on nnfs_pkg for field widths.
interface nnfs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [nnfs_pkg::PIX_W-1:0]    pixel;
  logic [nnfs_pkg::PAL_AW-1:0]   pal_index;
  logic [nnfs_pkg::WORD_W-1:0]   pal_word;

  modport source(output valid, func, pixel, pal_index, pal_word, input ready);
  modport sink(input valid, func, pixel, pal_index, pal_word, output ready);
endinterface

FILE: design/nnfs_out_if.sv
// Result channel of the frame scaler: one output pixel per item.
// Depends on nnfs_pkg for field widths.
interface nnfs_out_if;
  logic                          valid;
  logic                          ready;
  logic [nnfs_pkg::WORD_W-1:0]   out_value;
  logic [nnfs_pkg::COORD_W-1:0]  out_col;
  logic [nnfs_pkg::COORD_W-1:0]  out_line;
  logic                          run_last;
  logic                          frame_last;

  modport source(output valid, out_value, out_col, out_line, run_last, frame_last,
                 input ready);
  modport sink(input valid, out_value, out_col, out_line, run_last, frame_last,
               output ready);
endinterface

FILE: design/nnfs_cfg_if.sv
// Configuration write channel of the frame scaler.
// Depends on nnfs_pkg for the index and data widths.
interface nnfs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [nnfs_pkg::CFG_IDX_W-1:0]  index;
  logic [nnfs_pkg::REG_W-1:0]      data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: design/nnfs_div.sv
// Column step unit: divides by a constant through a reciprocal multiplication.
// The quotient is registered every cycle and busy covers the cycle after a start.
// Depends on nothing else.
module nnfs_div #(
  parameter int NUM_W   = 29,
  parameter int DIVISOR = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int              LOG_D  = $clog2(DIVISOR);
  localparam int              SHIFT  = NUM_W + LOG_D;
  localparam int              MUL_W  = NUM_W + 1;
  localparam int              PROD_W = NUM_W + MUL_W;
  localparam longint unsigned RECIP  =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic              busy_r, busy_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [PROD_W-1:0] prod;

  assign busy     = busy_r;
  assign quot     = quo_r;
  assign prod     = PROD_W'(numer) * PROD_W'(MUL_W'(RECIP));
  assign busy_nxt = start;
  assign quo_nxt  = NUM_W'(prod >> SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

endmodule

FILE: design/nnfs_palette.sv
// Palette store, 256 words of 32 bits, one write and one registered read port.
// Depends on nnfs_pkg for widths.
module nnfs_palette (
  input  logic                          clk,
  input  logic                          we,
  input  logic [nnfs_pkg::PAL_AW-1:0]   waddr,
  input  logic [nnfs_pkg::WORD_W-1:0]   wdata,
  input  logic                          re,
  input  logic [nnfs_pkg::PAL_AW-1:0]   raddr,
  output logic [nnfs_pkg::WORD_W-1:0]   rdata
);

  logic [nnfs_pkg::WORD_W-1:0] mem [nnfs_pkg::PAL_DEPTH];
  logic [nnfs_pkg::WORD_W-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

FILE: design/nearest_neighbor_frame_scaler.sv
// A source pixel yields its n results from the emit state entered after acceptance, each
// registered, one per cycle under the sample sequencer while out_ch.ready does not stall.
// After reset and after each src_cols write the column step is rebuilt by a reciprocal
// multiply, with the input not ready while the divider is started and busy.
// Reset: synchronous active-low rst_n clears counters and out_valid, sets config defaults.
// Top level; depends on nnfs_pkg, the channel interfaces, nnfs_div and nnfs_palette.
`include "nearest_neighbor_frame_scaler_assert.svh"

module nearest_neighbor_frame_scaler #(
  parameter int DEST_SIZE = 256,
  parameter int MAX_SRC   = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  nnfs_in_if.sink     in_ch,
  nnfs_out_if.source  out_ch,
  nnfs_cfg_if.sink    cfg_ch
);

  localparam int CBW = $clog2(MAX_SRC + 1);
  localparam int LW  = $clog2(DEST_SIZE + 1);
  localparam int XW  = (CBW > LW) ? CBW : LW;
  localparam int PW  = nnfs_pkg::FRAC_W + $clog2(MAX_SRC) + 2;
  localparam int NW  = nnfs_pkg::FRAC_W + CBW;
  localparam int AW  = $clog2(DEST_SIZE * MAX_SRC + 1);
  localparam int IW  = PW - nnfs_pkg::FRAC_W;
  localparam int RW  = nnfs_pkg::RES_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                         state_r, state_nxt;
  logic                         boot_r;
  logic [nnfs_pkg::REG_W-1:0]   src_cols_r, src_rows_r;
  logic                         pal_mode_r;

  logic [CBW-1:0] src_col_r, src_col_nxt;
  logic [CBW-1:0] src_line_r, src_line_nxt;
  logic [PW-1:0]  sample_pos_r, sample_pos_nxt;
  logic [LW-1:0]  dest_col_r, dest_col_nxt;
  logic [LW-1:0]  dest_line_r, dest_line_nxt;
  logic [AW-1:0]  acc_r, acc_nxt;
  logic [AW-1:0]  base_r, base_nxt;
  logic [RW-1:0]  n_r, n_nxt;
  logic           sel_r, sel_nxt;
  logic [PW-1:0]  pt_r, pt_nxt;
  logic [nnfs_pkg::PIX_W-1:0] pix_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [nnfs_pkg::WORD_W-1:0]   out_value_r;
  logic [nnfs_pkg::COORD_W-1:0]  out_col_r, out_line_r;
  logic                          out_run_last_r, out_frame_last_r;

  logic [CBW-1:0] cols, rows;
  logic [XW-1:0]  trows;
  logic [PW-1:0]  step, half, pt_next;
  logic [NW-1:0]  quot;
  logic           div_busy, kick_div, cfg_wr, accept;
  logic           sel_now, cur_ok, nxt_ok, out_load, finish;
  logic [CBW-1:0] col_inc, line_inc;
  logic [nnfs_pkg::WORD_W-1:0] pal_rdata, value;

  always_comb begin
    if (src_cols_r < nnfs_pkg::REG_W'(nnfs_pkg::MIN_COLS)) begin
      cols = CBW'(nnfs_pkg::MIN_COLS);
    end else if (32'(src_cols_r) > 32'(MAX_SRC)) begin
      cols = CBW'(MAX_SRC);
    end else begin
      cols = CBW'(src_cols_r);
    end
    if (src_rows_r == '0) begin
      rows = CBW'(1);
    end else if (32'(src_rows_r) > 32'(MAX_SRC)) begin
      rows = CBW'(MAX_SRC);
    end else begin
      rows = CBW'(src_rows_r);
    end
    trows = (XW'(rows) <= XW'(DEST_SIZE)) ? XW'(rows) : XW'(DEST_SIZE);
  end

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;
  assign kick_div     = boot_r || (cfg_wr && cfg_ch.index == nnfs_pkg::REG_SRC_COLS);

  nnfs_div #(
    .NUM_W   (NW),
    .DIVISOR (DEST_SIZE)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (kick_div),
    .numer ({cols, nnfs_pkg::FRAC_W'(0)}),
    .busy  (div_busy),
    .quot  (quot)
  );

  assign step = PW'(quot);
  assign half = step >> 1;

  assign in_ch.ready = (state_r == ST_IDLE) && !div_busy && !kick_div;
  assign accept      = in_ch.valid && in_ch.ready;

  nnfs_palette u_pal (
    .clk   (clk),
    .we    (accept && in_ch.func == nnfs_pkg::FUNC_PAL_WRITE),
    .waddr (in_ch.pal_index),
    .wdata (in_ch.pal_word),
    .re    (accept && in_ch.func == nnfs_pkg::FUNC_PIXEL),
    .raddr (in_ch.pixel),
    .rdata (pal_rdata)
  );

  always_comb begin
    if (XW'(dest_line_r) >= trows) begin
      sel_now = 1'b0;
    end else if (XW'(rows) <= XW'(DEST_SIZE)) begin
      sel_now = XW'(dest_line_r) == XW'(src_line_r);
    end else begin
      sel_now = (acc_r >= base_r) && (acc_r < base_r + AW'(DEST_SIZE));
    end
  end

  assign pt_next = pt_r + step;
  assign cur_ok  = sel_r && (n_r < RW'(nnfs_pkg::MAX_RESULTS))
                && (dest_col_r < LW'(DEST_SIZE))
                && (pt_r[PW-1:nnfs_pkg::FRAC_W] <= IW'(src_col_r));
  assign nxt_ok  = (n_r < RW'(nnfs_pkg::MAX_RESULTS - 1))
                && (dest_col_r < LW'(DEST_SIZE - 1))
                && (pt_next[PW-1:nnfs_pkg::FRAC_W] <= IW'(src_col_r));
  assign out_load = (state_r == ST_EMIT) && cur_ok && (!out_valid_r || out_ch.ready);
  assign finish   = (state_r == ST_EMIT) && !cur_ok;
  assign value    = pal_mode_r ? pal_rdata : nnfs_pkg::WORD_W'(pix_r);
  assign col_inc  = src_col_r + CBW'(1);
  assign line_inc = src_line_r + CBW'(1);

  always_comb begin
    state_nxt      = state_r;
    src_col_nxt    = src_col_r;
    src_line_nxt   = src_line_r;
    sample_pos_nxt = sample_pos_r;
    dest_col_nxt   = dest_col_r;
    dest_line_nxt  = dest_line_r;
    acc_nxt        = acc_r;
    base_nxt       = base_r;
    n_nxt          = n_r;
    sel_nxt        = sel_r;
    pt_nxt         = pt_r;
    out_valid_nxt  = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_ch.func == nnfs_pkg::FUNC_PIXEL) begin
          state_nxt = ST_EMIT;
          sel_nxt   = sel_now;
          n_nxt     = '0;
          pt_nxt    = sample_pos_r + half;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          pt_nxt         = pt_next;
          sample_pos_nxt = sample_pos_r + step;
          dest_col_nxt   = dest_col_r + LW'(1);
          n_nxt          = n_r + RW'(1);
        end else if (finish) begin
          state_nxt = ST_IDLE;
          if (col_inc >= cols) begin
            src_col_nxt    = '0;
            dest_col_nxt   = '0;
            sample_pos_nxt = '0;
            if (line_inc >= rows) begin
              src_line_nxt  = '0;
              dest_line_nxt = '0;
              acc_nxt       = '0;
              base_nxt      = '0;
            end else begin
              src_line_nxt = line_inc;
              base_nxt     = base_r + AW'(DEST_SIZE);
              if (sel_r) begin
                dest_line_nxt = dest_line_r + LW'(1);
                acc_nxt       = acc_r + AW'(rows);
              end
            end
          end else begin
            src_col_nxt = col_inc;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      boot_r       <= 1'b1;
      src_cols_r   <= nnfs_pkg::RST_SRC_COLS;
      src_rows_r   <= nnfs_pkg::RST_SRC_ROWS;
      pal_mode_r   <= 1'b1;
      src_col_r    <= '0;
      src_line_r   <= '0;
      sample_pos_r <= '0;
      dest_col_r   <= '0;
      dest_line_r  <= '0;
      acc_r        <= '0;
      base_r       <= '0;
      n_r          <= '0;
      sel_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      boot_r       <= 1'b0;
      if (cfg_wr) begin
        unique case (cfg_ch.index)
          nnfs_pkg::REG_SRC_COLS: src_cols_r <= cfg_ch.data;
          nnfs_pkg::REG_SRC_ROWS: src_rows_r <= cfg_ch.data;
          nnfs_pkg::REG_PAL_MODE: pal_mode_r <= cfg_ch.data[0];
          default: begin
          end
        endcase
      end
      src_col_r    <= src_col_nxt;
      src_line_r   <= src_line_nxt;
      sample_pos_r <= sample_pos_nxt;
      dest_col_r   <= dest_col_nxt;
      dest_line_r  <= dest_line_nxt;
      acc_r        <= acc_nxt;
      base_r       <= base_nxt;
      n_r          <= n_nxt;
      sel_r        <= sel_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pt_r <= pt_nxt;
    if (accept) begin
      pix_r <= in_ch.pixel;
    end
    if (out_load) begin
      out_value_r      <= value;
      out_col_r        <= nnfs_pkg::COORD_W'(dest_col_r);
      out_line_r       <= nnfs_pkg::COORD_W'(dest_line_r);
      out_run_last_r   <= !nxt_ok;
      out_frame_last_r <= (dest_col_r == LW'(DEST_SIZE - 1))
                       && (XW'(dest_line_r) == trows - XW'(1));
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_value  = out_value_r;
  assign out_ch.out_col    = out_col_r;
  assign out_ch.out_line   = out_line_r;
  assign out_ch.run_last   = out_run_last_r;
  assign out_ch.frame_last = out_frame_last_r;

  `NNFS_ASSERT_IMP(a_ready_only_idle, clk, rst_n, in_ch.ready, !div_busy && state_r == ST_IDLE, "input ready while busy")
  `NNFS_ASSERT_IMP(a_result_cap, clk, rst_n, out_load, n_r < RW'(nnfs_pkg::MAX_RESULTS), "result cap exceeded")
  `NNFS_ASSERT_NXT(a_load_valid, clk, rst_n, out_load, out_valid_r, "loaded result not shown")
  `NNFS_ASSERT_IMP(a_frame_last_col, clk, rst_n, out_valid_r && out_frame_last_r, out_col_r == nnfs_pkg::COORD_W'(DEST_SIZE - 1), "frame end off the last column")

endmodule
